@@ src/rational_fraction_alu_unit_macros.svh @@
`ifndef RATIONAL_FRACTION_ALU_UNIT_MACROS_SVH
`define RATIONAL_FRACTION_ALU_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RFA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rfa_pkg.sv @@
`timescale 1ns / 1ps

package rfa_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int MODE_W            = 3;
	localparam int NUM_OUT_W         = 33;
	localparam int DEN_OUT_W         = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD_RED = 3'd0,
		MODE_MUL_RED = 3'd1,
		MODE_EQ      = 3'd2,
		MODE_NE      = 3'd3,
		MODE_ADD_RAW = 3'd4
	} mode_t;

	typedef enum logic {
		OP_GCD = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} eng_req_t;

endpackage

@@ src/rfa_mul.sv @@
`timescale 1ns / 1ps

module rfa_mul
	import rfa_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic [OPERAND_WIDTH-1:0]     a,
	input  logic [OPERAND_WIDTH-1:0]     b,
	output logic [2*OPERAND_WIDTH-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= (2*OPERAND_WIDTH)'(a) * (2*OPERAND_WIDTH)'(b);
	end

endmodule

@@ src/rfa_engine.sv @@
`timescale 1ns / 1ps

module rfa_engine
	import rfa_pkg::*;
#(
	parameter int DW = 2*OPERAND_WIDTH_DEF+1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  eng_req_t      req,
	input  logic [DW-1:0] opa,
	input  logic [DW-1:0] opb,
	output logic          done,
	output logic [DW-1:0] res
);

	localparam int KW = $clog2(DW+1);

	logic          busy_q;
	logic          done_q;
	op_t           op_q;
	logic [DW-1:0] x_q;
	logic [DW-1:0] y_q;
	logic [DW-1:0] d_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] cnt_q;
	logic [DW-1:0] res_q;

	logic          x_gt_y;
	logic [DW:0]   rem_sh;
	logic [DW:0]   sub_a;
	logic [DW:0]   sub_b;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] quo_nxt;

	// one subtractor: gcd difference or restoring-division trial
	always_comb begin
		x_gt_y  = x_q > y_q;
		rem_sh  = {x_q, y_q[DW-1]};
		if (op_q == OP_DIV) begin
			sub_a = rem_sh;
			sub_b = {1'b0, d_q};
		end else if (x_gt_y) begin
			sub_a = {1'b0, x_q};
			sub_b = {1'b0, y_q};
		end else begin
			sub_a = {1'b0, y_q};
			sub_b = {1'b0, x_q};
		end
		diff    = sub_a - sub_b;
		ge      = !diff[DW];
		quo_nxt = {y_q[DW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_GCD;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					op_q   <= req.op;
					k_q    <= '0;
					cnt_q  <= '0;
					d_q    <= opb;
					if (req.op == OP_DIV) begin
						x_q <= '0;
						y_q <= opa;
					end else begin
						x_q <= opa;
						y_q <= opb;
					end
				end
			end else begin
				unique case (op_q)
					OP_GCD: begin
						// binary gcd, both terms known nonzero
						priority if (x_q == y_q) begin
							res_q  <= x_q << k_q;
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else if (!x_q[0] && !y_q[0]) begin
							x_q <= x_q >> 1;
							y_q <= y_q >> 1;
							k_q <= k_q + KW'(1);
						end else if (!x_q[0]) begin
							x_q <= x_q >> 1;
						end else if (!y_q[0]) begin
							y_q <= y_q >> 1;
						end else if (x_gt_y) begin
							x_q <= diff[DW-1:0];
						end else begin
							y_q <= diff[DW-1:0];
						end
					end
					OP_DIV: begin
						x_q   <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
						y_q   <= quo_nxt;
						cnt_q <= cnt_q + KW'(1);
						if (cnt_q == KW'(DW-1)) begin
							res_q  <= quo_nxt;
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ src/rational_fraction_alu_unit.sv @@
`timescale 1ns / 1ps
// sequence: compare and unused modes, and any arithmetic item with an empty operand, go from
// accept to ST_FIN; unreduced add runs ST_MUL0 to ST_MUL3, then ST_FIN; reduced add and
// multiply follow ST_MUL3 with ST_GCD (one binary gcd step per cycle), ST_DIVN and ST_DIVD
// throughput: one item at a time, busy stays high until done; set by the shared gcd/divider
// the receiver cannot stall: done is high for exactly one cycle per item
// reset: arst_n clears the sequencer and engine control, any item in flight is dropped

module rational_fraction_alu_unit
	import rfa_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-1:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-1:0] b_den,
	output logic                     done,
	output logic [NUM_OUT_W-1:0]     out_num,
	output logic [DEN_OUT_W-1:0]     out_den,
	output logic                     compare_true,
	output logic                     out_empty
);

	localparam int PROD_W = 2*OPERAND_WIDTH;
	localparam int NW     = 2*OPERAND_WIDTH+1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} state_t;

	state_t                   state_q;
	logic [MODE_W-1:0]        mode_q;
	logic [OPERAND_WIDTH-1:0] an_q;
	logic [OPERAND_WIDTH-1:0] ad_q;
	logic [OPERAND_WIDTH-1:0] bn_q;
	logic [OPERAND_WIDTH-1:0] bd_q;
	logic [NW-1:0]            num_q;
	logic [PROD_W-1:0]        den_q;
	logic [NW-1:0]            g_q;
	logic                     cmp_q;

	logic [OPERAND_WIDTH-1:0] mul_a;
	logic [OPERAND_WIDTH-1:0] mul_b;
	logic [PROD_W-1:0]        p_q;

	eng_req_t                 eng_req;
	logic [NW-1:0]            eng_opa;
	logic [NW-1:0]            eng_opb;
	logic                     eng_done;
	logic [NW-1:0]            eng_res;

	logic                     a_empty;
	logic                     b_empty;
	logic                     arith_mode;

	assign a_empty    = (a_num == '0) && (a_den == '0);
	assign b_empty    = (b_num == '0) && (b_den == '0);
	assign arith_mode = (mode_q == MODE_ADD_RED) || (mode_q == MODE_MUL_RED) ||
		(mode_q == MODE_ADD_RAW);
	assign busy       = (state_q != ST_IDLE);

	rfa_mul #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	rfa_engine #(
		.DW(NW)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (eng_req),
		.opa    (eng_opa),
		.opb    (eng_opb),
		.done   (eng_done),
		.res    (eng_res)
	);

	always_comb begin
		unique case (state_q)
			ST_MUL0: begin
				mul_a = an_q;
				mul_b = (mode_q == MODE_MUL_RED) ? bn_q : bd_q;
			end
			ST_MUL1: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
		endcase
	end

	// gcd after the last product, then numerator and denominator divisions
	always_comb begin
		eng_req.start = 1'b0;
		eng_req.op    = OP_GCD;
		eng_opa       = num_q;
		eng_opb       = NW'(p_q);
		unique case (state_q)
			ST_MUL3: begin
				eng_req.start = (mode_q != MODE_ADD_RAW) && (num_q != '0) && (p_q != '0);
			end
			ST_GCD: begin
				eng_req.start = eng_done;
				eng_req.op    = OP_DIV;
				eng_opb       = eng_res;
			end
			ST_DIVN: begin
				eng_req.start = eng_done;
				eng_req.op    = OP_DIV;
				eng_opa       = NW'(den_q);
				eng_opb       = g_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q <= mode;
						an_q   <= a_num;
						ad_q   <= a_den;
						bn_q   <= b_num;
						bd_q   <= b_den;
						num_q  <= '0;
						den_q  <= '0;
						cmp_q  <= 1'b0;
						state_q <= ST_FIN;
						unique case (mode)
							MODE_ADD_RED, MODE_MUL_RED: begin
								if (!a_empty && !b_empty) begin
									state_q <= ST_MUL0;
								end
							end
							MODE_EQ: begin
								cmp_q <= !a_empty && !b_empty && (a_num == b_num) &&
									(a_den == b_den);
							end
							MODE_NE: begin
								cmp_q <= !a_empty && !b_empty &&
									((a_num != b_num) || (a_den != b_den));
							end
							MODE_ADD_RAW: begin
								if (a_empty || b_empty) begin
									num_q <= NW'(a_num);
									den_q <= PROD_W'(a_den);
								end else begin
									state_q <= ST_MUL0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL0: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					num_q   <= NW'(p_q);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (mode_q != MODE_MUL_RED) begin
						num_q <= num_q + NW'(p_q);
					end
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					den_q <= p_q;
					// no reduction in unreduced add or when the smaller term is zero
					if (eng_req.start) begin
						state_q <= ST_GCD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_GCD: begin
					if (eng_done) begin
						g_q     <= eng_res;
						state_q <= ST_DIVN;
					end
				end
				ST_DIVN: begin
					if (eng_done) begin
						num_q   <= eng_res;
						state_q <= ST_DIVD;
					end
				end
				ST_DIVD: begin
					if (eng_done) begin
						den_q   <= PROD_W'(eng_res);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					out_num      <= NUM_OUT_W'(num_q);
					out_den      <= DEN_OUT_W'(den_q);
					compare_true <= cmp_q;
					out_empty    <= arith_mode && (num_q == '0) && (den_q == '0);
					done         <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/rfa_checker.sv @@
`timescale 1ns / 1ps
`include "rational_fraction_alu_unit_macros.svh"

module rfa_checker
	import rfa_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [NUM_OUT_W-1:0] out_num,
	input logic [DEN_OUT_W-1:0] out_den,
	input logic                 compare_true,
	input logic                 out_empty
);

	// a transfer in always makes the unit busy
	`RFA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
	`RFA_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")
	`RFA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held past one cycle")
	`RFA_ASSERT_SAME(a_cmp_clean, done && compare_true,
		(out_num == '0) && (out_den == '0) && !out_empty, "compare result with fraction")
	`RFA_ASSERT_SAME(a_empty_clean, done && out_empty,
		(out_num == '0) && (out_den == '0) && !compare_true, "empty result not 0/0")

endmodule

bind rational_fraction_alu_unit rfa_checker u_rfa_checker (.*);
